>>> rtl/core/bdm_pkg.sv
// shared types and constants for the button debouncer with multi-press and long-hold
`default_nettype none
package bdm_pkg;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned DebounceW = 16;
  localparam int unsigned WindowW   = 16;
  localparam int unsigned HoldW     = 20;
  localparam int unsigned CountW    = 8;
  localparam int unsigned CfgDataW  = 20;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [DebounceW-1:0] DebounceReset = 16'd50;
  localparam logic [WindowW-1:0]   WindowReset   = 16'd400;
  localparam logic [HoldW-1:0]     HoldReset     = 20'd5000;
  localparam logic [CountW-1:0]    CountMax      = 8'd255;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgDebounce = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWindow   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgLongHold = 2'd2;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_SINGLE = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_MULTI  = 3'd3,
    EV_HOLD   = 3'd4
  } event_kind_e;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             button_level;
  } in_item_t;

  typedef struct packed {
    event_kind_e       event_kind;
    logic [CountW-1:0] press_count;
    logic              stable_level;
  } out_item_t;

  typedef struct packed {
    logic [DebounceW-1:0] debounce_ms;
    logic [WindowW-1:0]   multi_press_window_ms;
    logic [HoldW-1:0]     long_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic              raw_seen;
    logic              debounced;
    logic [TimeW-1:0]  change_time;
    logic [TimeW-1:0]  press_start_time;
    logic [TimeW-1:0]  release_time;
    logic [CountW-1:0] short_count;
    logic              hold_reported;
  } state_t;

endpackage
`default_nettype wire

>>> rtl/core/bdm_step.sv
// next-state and result logic for one button poll
`default_nettype none
module bdm_step (
  input  bdm_pkg::cfg_t      cfg_i,
  input  bdm_pkg::state_t    state_i,
  input  bdm_pkg::in_item_t  item_i,
  output bdm_pkg::state_t    state_o,
  output bdm_pkg::out_item_t result_o
);
  import bdm_pkg::*;

  logic [TimeW-1:0]  d_change, d_press, d_release;
  logic              same_level, fire, fire_press, fire_release;
  logic              held_short, count_release, in_window, hold_fire, report;
  logic              hold_after_press;
  logic [CountW-1:0] count_after_release, count_after_hold;

  // all differences against registered state, taken in parallel
  assign d_change  = item_i.now_ms - state_i.change_time;
  assign d_press   = item_i.now_ms - state_i.press_start_time;
  assign d_release = item_i.now_ms - state_i.release_time;

  // a raw change restarts the timer, so it can never debounce on the same poll
  assign same_level   = (item_i.button_level == state_i.raw_seen);
  assign fire         = same_level && (state_i.debounced != state_i.raw_seen) &&
                        (d_change > {{(TimeW-DebounceW){1'b0}}, cfg_i.debounce_ms});
  assign fire_press   = fire && !state_i.raw_seen;
  assign fire_release = fire && state_i.raw_seen;

  assign held_short    = d_press < {{(TimeW-HoldW){1'b0}}, cfg_i.long_hold_ms};
  assign count_release = fire_release && !state_i.hold_reported && held_short;
  assign in_window     = d_release <= {{(TimeW-WindowW){1'b0}}, cfg_i.multi_press_window_ms};

  always_comb begin
    count_after_release = state_i.short_count;
    if (count_release) begin
      if (!in_window) begin
        count_after_release = CountW'(1);
      end else if (state_i.short_count != CountMax) begin
        count_after_release = state_i.short_count + CountW'(1);
      end
    end
  end

  assign hold_after_press = fire_press ? 1'b0 : state_i.hold_reported;

  // on a fresh press the hold time is zero, so only a zero limit fires at once
  assign hold_fire = !(fire ? state_i.raw_seen : state_i.debounced) && !hold_after_press &&
                     (fire_press ? (cfg_i.long_hold_ms == '0) : !held_short);

  assign count_after_hold = hold_fire ? '0 : count_after_release;

  // a counted release resets the gap to zero, which is never past the window
  assign report = (fire ? state_i.raw_seen : state_i.debounced) &&
                  (count_after_hold != '0) && !count_release && !in_window;

  always_comb begin
    state_o                  = state_i;
    state_o.raw_seen         = item_i.button_level;
    if (!same_level || fire) begin
      state_o.change_time    = item_i.now_ms;
    end
    if (fire) begin
      state_o.debounced      = state_i.raw_seen;
    end
    if (fire_press) begin
      state_o.press_start_time = item_i.now_ms;
    end
    if (count_release) begin
      state_o.release_time   = item_i.now_ms;
    end
    state_o.hold_reported    = hold_fire ? 1'b1 : hold_after_press;
    state_o.short_count      = report ? '0 : count_after_hold;
  end

  always_comb begin
    result_o.event_kind   = EV_NONE;
    result_o.press_count  = '0;
    result_o.stable_level = state_o.debounced;
    if (hold_fire) begin
      result_o.event_kind = EV_HOLD;
    end else if (report) begin
      result_o.press_count = count_after_hold;
      case (count_after_hold)
        CountW'(1): result_o.event_kind = EV_SINGLE;
        CountW'(2): result_o.event_kind = EV_DOUBLE;
        default:    result_o.event_kind = EV_MULTI;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/button_debounce_multipress_longhold.sv
// top level: button debouncer with multi-press counting and long-hold detection
// path: an accepted input beat is held in the input register, its result in the result register
// throughput: one poll per cycle while the result register is not stalled; the state update is
// a single pass of subtract/compare logic between the input register and the result register
// reset: async active low; debounced and raw levels released, times and count zero,
// config back to debounce 50, window 400, long hold 5000
`default_nettype none
module button_debounce_multipress_longhold (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_stall_o,
  input  bdm_pkg::in_item_t          in_item_i,
  output logic                       out_valid_o,
  input  wire                        out_stall_i,
  output bdm_pkg::out_item_t         out_item_o,
  input  wire                        cfg_we_i,
  input  wire [bdm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire [bdm_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import bdm_pkg::*;

  cfg_t      cfg_q;
  state_t    state_q, state_d;
  in_item_t  in_item_q;
  logic      in_valid_q;
  out_item_t out_item_q, result_d;
  logic      out_valid_q;
  logic      out_hold;   // result register full and not drained this cycle
  logic      advance;    // input beat moves through the step logic

  assign out_hold   = out_valid_q && out_stall_i;
  assign in_stall_o = in_valid_q && out_hold;
  assign advance    = in_valid_q && !out_hold;

  // configuration registers, plain write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms           <= DebounceReset;
      cfg_q.multi_press_window_ms <= WindowReset;
      cfg_q.long_hold_ms          <= HoldReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDebounce: cfg_q.debounce_ms           <= cfg_wdata_i[DebounceW-1:0];
        CfgWindow:   cfg_q.multi_press_window_ms <= cfg_wdata_i[WindowW-1:0];
        CfgLongHold: cfg_q.long_hold_ms          <= cfg_wdata_i[HoldW-1:0];
        default: ;   // unknown index ignored
      endcase
    end
  end

  // input register: takes a beat when empty or when its beat moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
  end

  bdm_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (in_item_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // debounce / press tracking state, updated once per poll
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.raw_seen         <= 1'b1;
      state_q.debounced        <= 1'b1;
      state_q.change_time      <= '0;
      state_q.press_start_time <= '0;
      state_q.release_time     <= '0;
      state_q.short_count      <= '0;
      state_q.hold_reported    <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_hold) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  // long hold only while the button is down and never carries a count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.event_kind == EV_HOLD |->
      !out_item_o.stable_level && out_item_o.press_count == '0)
    else $error("long-hold beat with level up or nonzero count");

  // press reports only with the button up and a nonzero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.event_kind == EV_SINGLE ||
                    out_item_o.event_kind == EV_DOUBLE ||
                    out_item_o.event_kind == EV_MULTI) |->
      out_item_o.stable_level && out_item_o.press_count != '0)
    else $error("press report with level down or zero count");

  // count field is zero on beats without a press pattern
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.event_kind == EV_NONE |-> out_item_o.press_count == '0)
    else $error("count on a beat without event");

  // state only moves when a poll passes through the step logic
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("state changed without a poll");
`endif

endmodule
`default_nettype wire

>>> tb/button_debounce_multipress_longhold_tb.sv
// self-checking testbench for the button debouncer: directed poll table, then random click traffic
module button_debounce_multipress_longhold_tb;
  import bdm_pkg::*;

  // index with no register behind it, the block must drop the write
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  // one directed poll, with an optional hand-written result
  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             level;
    logic             known;
    out_item_t        result;
  } poll_row_t;

  // per accepted beat: use the hand-written result instead of the prediction
  typedef struct packed {
    logic      known;
    out_item_t result;
  } typed_event_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_item_t            in_item_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_item_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  // predictor copy of the block's registers and button state
  cfg_t   regs;
  state_t btn;

  out_item_t    expected_events[$];
  typed_event_t typed_events[$];
  poll_row_t    script[$];

  int unsigned  mismatch_count = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  stall_pct = 0;
  int unsigned  phase_polls;
  logic [TimeW-1:0] clock_ms;

  // monitor scratch
  typed_event_t typed_now;
  out_item_t    predicted;
  out_item_t    wanted;

  button_debounce_multipress_longhold dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  // one poll through the debouncer: updates btn, returns the result beat
  function automatic out_item_t debounce_poll(input in_item_t poll);
    out_item_t        res;
    logic [TimeW-1:0] held;
    res.event_kind   = EV_NONE;
    res.press_count  = '0;
    res.stable_level = 1'b0;
    // any raw edge restarts the stability timer
    if (poll.button_level != btn.raw_seen) begin
      btn.raw_seen    = poll.button_level;
      btn.change_time = poll.now_ms;
    end
    // raw level held strictly longer than the debounce time becomes the stable level
    if (TimeW'(poll.now_ms - btn.change_time) > regs.debounce_ms &&
        btn.debounced != btn.raw_seen) begin
      btn.debounced   = btn.raw_seen;
      btn.change_time = poll.now_ms;
      if (!btn.debounced) begin
        btn.press_start_time = poll.now_ms;
        btn.hold_reported    = 1'b0;
      end else begin
        held = poll.now_ms - btn.press_start_time;
        // a release before the hold limit is a short press
        if (!btn.hold_reported && held < regs.long_hold_ms) begin
          if (TimeW'(poll.now_ms - btn.release_time) <= regs.multi_press_window_ms) begin
            if (btn.short_count != CountMax) begin
              btn.short_count = btn.short_count + 1'b1;
            end
          end else begin
            btn.short_count = 8'd1;
          end
          btn.release_time = poll.now_ms;
        end
      end
    end
    // long hold fires once per press and throws away the pending count
    if (!btn.debounced && !btn.hold_reported &&
        TimeW'(poll.now_ms - btn.press_start_time) >= regs.long_hold_ms) begin
      btn.hold_reported = 1'b1;
      btn.short_count   = '0;
      res.event_kind    = EV_HOLD;
    end
    // button up and the window passed since the last release: report the count
    if (btn.debounced && btn.short_count != '0 &&
        TimeW'(poll.now_ms - btn.release_time) > regs.multi_press_window_ms) begin
      res.press_count = btn.short_count;
      btn.short_count = '0;
      case (res.press_count)
        8'd1:    res.event_kind = EV_SINGLE;
        8'd2:    res.event_kind = EV_DOUBLE;
        default: res.event_kind = EV_MULTI;
      endcase
    end
    res.stable_level = btn.debounced;
    return res;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // accepted polls feed the predictor, accepted result beats are checked in order
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        typed_now = '0;
        if (typed_events.size() != 0) begin
          typed_now = typed_events.pop_front();
        end
        predicted = debounce_poll(in_item_i);
        expected_events.push_back(typed_now.known ? typed_now.result : predicted);
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_events.size() == 0) begin
          note_mismatch("beat with nothing pending, kind", 32'(out_item_o.event_kind), 0);
        end else begin
          wanted = expected_events.pop_front();
          if (out_item_o.event_kind != wanted.event_kind) begin
            note_mismatch("event_kind", 32'(out_item_o.event_kind), 32'(wanted.event_kind));
          end
          if (out_item_o.press_count != wanted.press_count) begin
            note_mismatch("press_count", 32'(out_item_o.press_count), 32'(wanted.press_count));
          end
          if (out_item_o.stable_level != wanted.stable_level) begin
            note_mismatch("stable_level", 32'(out_item_o.stable_level),
                          32'(wanted.stable_level));
          end
        end
      end
    end
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // drive one poll beat, holding it until the block takes it
  task automatic send_poll(input in_item_t item, input logic known, input out_item_t result);
    typed_events.push_back('{known: known, result: result});
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // advance the millisecond clock and poll the pin
  task automatic poll_at(input logic [TimeW-1:0] delta, input logic level);
    in_item_t item;
    clock_ms          = clock_ms + delta;
    item.now_ms       = clock_ms;
    item.button_level = level;
    phase_polls++;
    send_poll(item, 1'b0, '0);
  endtask

  task automatic add_row(input logic [TimeW-1:0] now_ms, input logic level, input logic known,
                         input event_kind_e kind, input logic [CountW-1:0] count,
                         input logic stable);
    poll_row_t row;
    row.now_ms              = now_ms;
    row.level               = level;
    row.known               = known;
    row.result.event_kind   = kind;
    row.result.press_count  = count;
    row.result.stable_level = stable;
    script.push_back(row);
  endtask

  // register write, only issued while the block is idle
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CfgDebounce: regs.debounce_ms           = data[DebounceW-1:0];
      CfgWindow:   regs.multi_press_window_ms = data[WindowW-1:0];
      CfgLongHold: regs.long_hold_ms          = data[HoldW-1:0];
      default:     ;
    endcase
  endtask

  // wait until every expected beat is back, then let the pipeline settle
  task automatic drain();
    @(posedge clk_i);
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // one press and release; tight keeps presses tiny and releases close together
  task automatic click(input bit tight);
    logic [TimeW-1:0] dur;
    logic [TimeW-1:0] gap;
    logic [TimeW-1:0] deb;
    logic [TimeW-1:0] win;
    logic [TimeW-1:0] hold;
    deb  = regs.debounce_ms;
    win  = regs.multi_press_window_ms;
    hold = regs.long_hold_ms;
    if (tight || $urandom_range(0, 1)) begin
      dur = $urandom_range(0, 20);
    end else if ($urandom_range(0, 1)) begin
      dur = $urandom_range(0, hold);
    end else begin
      dur = hold + $urandom_range(0, 50);
    end
    if (tight || $urandom_range(0, 1)) begin
      gap = $urandom_range(0, win / 4);
    end else begin
      gap = win + 1 + $urandom_range(0, win);
    end
    poll_at($urandom_range(1, 5), 1'b0);
    poll_at(deb + 1 + $urandom_range(0, 2), 1'b0);  // press goes stable
    poll_at(dur, 1'b0);                              // may hit the hold limit
    poll_at($urandom_range(1, 5), 1'b1);
    poll_at(deb + 1 + $urandom_range(0, 2), 1'b1);  // release goes stable
    poll_at(gap, 1'b1);                              // inside or past the window
  endtask

  // reprogram while idle, then run clicks, glitches and noise
  task automatic run_phase(input logic [CfgDataW-1:0] deb, input logic [CfgDataW-1:0] win,
                           input logic [CfgDataW-1:0] hold, input int unsigned mode,
                           input bit burst);
    int unsigned pick;
    drain();
    write_reg(CfgDebounce, deb);
    write_reg(CfgWindow, win);
    write_reg(CfgLongHold, hold);
    // idling mix: none, sender gaps, receiver stalls, both
    case (mode % 4)
      0:       begin send_idle_pct = 0;  stall_pct = 0;  end
      1:       begin send_idle_pct = 48; stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  stall_pct = 48; end
      default: begin send_idle_pct = 26; stall_pct = 26; end
    endcase
    phase_polls = 0;
    if (burst) begin
      // a long run of close short presses, reported as one multi-press count
      repeat (40) click(1'b1);
      poll_at(regs.multi_press_window_ms + 1 + $urandom_range(0, 10), 1'b1);
    end else begin
      while (phase_polls < 35) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          click(1'b0);
        end else if (pick < 80) begin
          // bounce no longer than the debounce time
          poll_at($urandom_range(1, 5), 1'b0);
          poll_at($urandom_range(0, regs.debounce_ms), 1'b1);
        end else if (pick < 90) begin
          // any jump, forward or backward, any level
          poll_at($urandom(), 1'($urandom_range(0, 1)));
        end else begin
          poll_at($urandom_range(0, 2 * regs.multi_press_window_ms + 2), 1'b1);
        end
      end
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CfgDebounce;
    cfg_wdata_i = '0;
    clock_ms    = '0;
    regs.debounce_ms           = DebounceReset;
    regs.multi_press_window_ms = WindowReset;
    regs.long_hold_ms          = HoldReset;
    btn = '0;
    btn.raw_seen  = 1'b1;
    btn.debounced = 1'b1;

    // directed polls at reset settings: debounce 50, window 400, long hold 5000
    add_row(32'd0,    1'b1, 1'b1, EV_NONE, 8'd0, 1'b1);   // quiet after reset
    add_row(32'd100,  1'b0, 1'b0, EV_NONE, 8'd0, 1'b0);
    add_row(32'd151,  1'b0, 1'b1, EV_NONE, 8'd0, 1'b0);   // press goes stable
    add_row(32'd200,  1'b1, 1'b0, EV_NONE, 8'd0, 1'b0);
    add_row(32'd251,  1'b1, 1'b0, EV_NONE, 8'd0, 1'b0);
    add_row(32'd652,  1'b1, 1'b1, EV_SINGLE, 8'd1, 1'b1); // window over, single click
    // double click
    add_row(32'd1000, 1'b0, 1'b0, EV_NONE, 8'd0, 1'b0);
    add_row(32'd1051, 1'b0, 1'b0, EV_NONE, 8'd0, 1'b0);
    add_row(32'd1100, 1'b1, 1'b0, EV_NONE, 8'd0, 1'b0);
    add_row(32'd1151, 1'b1, 1'b0, EV_NONE, 8'd0, 1'b0);
    add_row(32'd1200, 1'b0, 1'b0, EV_NONE, 8'd0, 1'b0);
    add_row(32'd1251, 1'b0, 1'b0, EV_NONE, 8'd0, 1'b0);
    add_row(32'd1300, 1'b1, 1'b0, EV_NONE, 8'd0, 1'b0);
    add_row(32'd1351, 1'b1, 1'b0, EV_NONE, 8'd0, 1'b0);
    add_row(32'd1800, 1'b1, 1'b0, EV_NONE, 8'd0, 1'b0);
    // bounce that never settles
    add_row(32'd2000, 1'b0, 1'b0, EV_NONE, 8'd0, 1'b0);
    add_row(32'd2020, 1'b1, 1'b0, EV_NONE, 8'd0, 1'b0);
    // long hold exactly at the limit
    add_row(32'd3000, 1'b0, 1'b0, EV_NONE, 8'd0, 1'b0);
    add_row(32'd3051, 1'b0, 1'b0, EV_NONE, 8'd0, 1'b0);
    add_row(32'd8051, 1'b0, 1'b1, EV_HOLD, 8'd0, 1'b0);
    add_row(32'd9000, 1'b1, 1'b0, EV_NONE, 8'd0, 1'b0);
    add_row(32'd9051, 1'b1, 1'b0, EV_NONE, 8'd0, 1'b0);   // release after hold, no count
    // timestamp wrap, then time running backwards
    add_row(32'hFFFF_FFFF, 1'b0, 1'b0, EV_NONE, 8'd0, 1'b0);
    add_row(32'h0000_0040, 1'b0, 1'b0, EV_NONE, 8'd0, 1'b0);
    add_row(32'h0000_0010, 1'b1, 1'b0, EV_NONE, 8'd0, 1'b0);
    add_row(32'h0000_0050, 1'b1, 1'b0, EV_NONE, 8'd0, 1'b0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) begin
      send_poll('{now_ms: script[i].now_ms, button_level: script[i].level},
                script[i].known, script[i].result);
    end
    clock_ms = script[script.size() - 1].now_ms;
    in_valid_i <= 1'b0;

    // lowest settings: no debounce, no window, hold of one ms
    run_phase(20'd0, 20'd0, 20'd1, 1, 1'b0);
    // all ones on the data bus, upper bits dropped on the 16-bit registers;
    // the stray index write must not land anywhere
    run_phase(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 2, 1'b0);
    drain();
    write_reg(CfgUnused, 20'hFFFFF);
    // zero hold: every stable press is a long hold, no short press ever counts
    run_phase(20'd30, 20'd300, 20'd0, 3, 1'b0);
    // long multi-press run with a wide window
    run_phase(20'd3, 20'd65535, 20'd1000000, 0, 1'b1);
    run_phase(20'($urandom_range(0, 200)), 20'($urandom_range(0, 1000)),
              20'($urandom_range(1, 3000)), 1, 1'b0);
    run_phase(20'd50, 20'd400, 20'd5000, 2, 1'b0);
    run_phase(20'($urandom_range(0, 100)), 20'($urandom_range(100, 800)),
              20'($urandom_range(200, 2000)), 3, 1'b0);
    run_phase(20'($urandom_range(0, 30)), 20'($urandom_range(0, 65535)),
              20'($urandom_range(1, 1000000)), 0, 1'b0);

    drain();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> button_debounce_multipress_longhold.f
rtl/core/bdm_pkg.sv
rtl/core/bdm_step.sv
rtl/core/button_debounce_multipress_longhold.sv
tb/button_debounce_multipress_longhold_tb.sv
